// File: design/ppe_pkg.sv
// Shared types and constants for the palette pixel expander.
// No dependencies; every other design file but ppe_ram refers to this package by scoped names.
package ppe_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int INDEX_W         = 8;
    localparam int CHAN_W          = 8;
    localparam int RGB_W           = 3 * CHAN_W;
    localparam int COLOR_W         = 16;
    localparam int COUNT_W         = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register slot number, taken from paddr above the byte lane bits
    localparam logic REG_DEPTH_MODE = 1'b0;

    localparam logic [1:0] DEPTH_RESET = 2'd3;
    localparam logic [1:0] DEPTH_1BPP  = 2'd0;
    localparam logic [1:0] DEPTH_2BPP  = 2'd1;
    localparam logic [1:0] DEPTH_4BPP  = 2'd2;
    localparam logic [1:0] DEPTH_8BPP  = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_EXPAND = 1'b1;

    // one palette access issued by the splitter
    typedef struct packed {
        logic                   valid;
        logic                   write;
        logic [INDEX_W-1:0]     index;
        logic [RGB_W-1:0]       rgb;
        logic                   last;
    } issue_t;

    // state of the palette read stage
    typedef struct packed {
        logic valid;
        logic last;
        logic out_of_range;
    } rd_stage_t;

    function automatic logic [COLOR_W-1:0] pack_rgb16(input logic [RGB_W-1:0] rgb);
        return {rgb[23:19], rgb[15:11], 1'b0, rgb[7:3]};
    endfunction

endpackage

// File: design/ppe_pixel_if.sv
// Input channel: palette-load and pixel-byte beats.
// Depends on ppe_pkg for field widths.
interface ppe_pixel_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [ppe_pkg::CHAN_W-1:0]  pixel_byte;
    logic [ppe_pkg::INDEX_W-1:0] entry_index;
    logic [ppe_pkg::CHAN_W-1:0]  entry_red;
    logic [ppe_pkg::CHAN_W-1:0]  entry_green;
    logic [ppe_pkg::CHAN_W-1:0]  entry_blue;

    modport source (
        output valid, operation, pixel_byte, entry_index, entry_red, entry_green, entry_blue,
        input  ready
    );
    modport sink (
        input  valid, operation, pixel_byte, entry_index, entry_red, entry_green, entry_blue,
        output ready
    );
endinterface

// File: design/ppe_color_if.sv
// Output channel: one 16-bit display pixel per beat.
// Depends on ppe_pkg for field widths.
interface ppe_color_if;
    logic                        valid;
    logic                        ready;
    logic [ppe_pkg::COLOR_W-1:0] color_word;
    logic                        last_of_byte;

    modport source (
        output valid, color_word, last_of_byte,
        input  ready
    );
    modport sink (
        input  valid, color_word, last_of_byte,
        output ready
    );
endinterface

// File: design/palette_pixel_expander_core.sv
// Palette pixel expander: indexed bitmap bytes in, 16-bit display pixels out.
// Depends on ppe_pkg, ppe_pixel_if, ppe_color_if, ppe_ram, ppe_splitter, ppe_pack.
//
// in_ch carries two kinds of beat: operation 0 loads palette entry entry_index
// with entry_red/green/blue; operation 1 expands pixel_byte by depth_mode
// (1 bpp: 8 pixels LSB first; 2/4 bpp: 4/2 pixels MSB field first; 8 bpp: 1).
// out_ch returns one color_word per pixel, last_of_byte set on the final one.
// depth_mode sits at APB byte address 0; write it only while the block is idle.
// Pipeline: splitter, palette RAM read, pack into the output register.
// First pixel of a byte passes the splitter, RAM read and output registers.
// Throughput is one palette access per cycle while out_ch does not stall:
// a byte issues 8, 4, 2 or 1 palette reads and a palette load one write.
// in_ch.ready drops while the splitter still has pixels of a byte to issue.
// When out_ch stalls, the whole pipe holds; no beat is lost or repeated.
// Reset clears all valid state and sets depth_mode to 8 bpp; palette contents
// are undefined until loaded.
module palette_pixel_expander_core #(
    parameter int PALETTE_ENTRIES = ppe_pkg::PALETTE_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    ppe_pixel_if.sink                      in_ch,
    ppe_color_if.source                    out_ch
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    logic [1:0]                  depth_mode_reg;
    logic                        cfg_write;
    logic                        adv;
    ppe_pkg::issue_t             issue;
    ppe_pkg::rd_stage_t          rd_reg;
    ppe_pkg::rd_stage_t          rd_next;
    logic                        in_range;
    logic [ppe_pkg::RGB_W-1:0]   rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ppe_pkg::REG_DEPTH_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= ppe_pkg::DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            depth_mode_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == ppe_pkg::REG_DEPTH_MODE)
                    ? {{(ppe_pkg::APB_DATA_W-2){1'b0}}, depth_mode_reg} : '0;

    ppe_splitter u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .depth_mode (depth_mode_reg),
        .adv        (adv),
        .in_ch      (in_ch),
        .issue      (issue)
    );

    assign in_range = ({1'b0, issue.index} < (ppe_pkg::INDEX_W+1)'(PALETTE_ENTRIES));

    ppe_ram #(
        .WIDTH (ppe_pkg::RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (adv && issue.valid && issue.write && in_range),
        .waddr (issue.index[ADDR_W-1:0]),
        .wdata (issue.rgb),
        .re    (adv && issue.valid && !issue.write),
        .raddr (issue.index[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        rd_next.valid        = issue.valid && !issue.write;
        rd_next.last         = issue.last;
        rd_next.out_of_range = !in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
        end
        else if (adv)
        begin
            rd_reg <= rd_next;
        end
    end

    ppe_pack u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rd_reg),
        .rdata  (rdata),
        .adv    (adv),
        .out_ch (out_ch)
    );

endmodule

// File: design/ppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ppe_splitter.sv
// Stage 1: holds one input beat and issues one palette access per cycle while the pipe advances.
// Depends on ppe_pkg and ppe_pixel_if.
module ppe_splitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         depth_mode,
    input  logic               adv,
    ppe_pixel_if.sink          in_ch,
    output ppe_pkg::issue_t    issue
);

    logic                             busy_reg;
    logic                             busy_next;
    logic [ppe_pkg::COUNT_W-1:0]      k_reg;
    logic [ppe_pkg::COUNT_W-1:0]      k_next;
    logic                             op_reg;
    logic [ppe_pkg::CHAN_W-1:0]       byte_reg;
    logic [ppe_pkg::INDEX_W-1:0]      entry_reg;
    logic [ppe_pkg::RGB_W-1:0]        rgb_reg;

    logic [ppe_pkg::INDEX_W-1:0]      pix_index;
    logic                             pix_last;
    logic                             done;
    logic                             accept;

    always_comb
    begin
        pix_index = '0;
        pix_last  = 1'b0;
        case (depth_mode)
            ppe_pkg::DEPTH_1BPP:
            begin
                pix_index = {{(ppe_pkg::INDEX_W-1){1'b0}}, byte_reg[k_reg]};
                pix_last  = (k_reg == 3'd7);
            end
            ppe_pkg::DEPTH_2BPP:
            begin
                case (k_reg[1:0])
                    2'd0:    pix_index = {6'b0, byte_reg[7:6]};
                    2'd1:    pix_index = {6'b0, byte_reg[5:4]};
                    2'd2:    pix_index = {6'b0, byte_reg[3:2]};
                    default: pix_index = {6'b0, byte_reg[1:0]};
                endcase
                pix_last = (k_reg[1:0] == 2'd3);
            end
            ppe_pkg::DEPTH_4BPP:
            begin
                pix_index = k_reg[0] ? {4'b0, byte_reg[3:0]} : {4'b0, byte_reg[7:4]};
                pix_last  = k_reg[0];
            end
            default:
            begin
                pix_index = byte_reg;
                pix_last  = 1'b1;
            end
        endcase
    end

    assign done        = busy_reg && (op_reg == ppe_pkg::OP_WRITE || pix_last);
    assign in_ch.ready = adv && (!busy_reg || done);
    assign accept      = in_ch.valid && in_ch.ready;

    assign issue.valid = busy_reg;
    assign issue.write = (op_reg == ppe_pkg::OP_WRITE);
    assign issue.index = (op_reg == ppe_pkg::OP_WRITE) ? entry_reg : pix_index;
    assign issue.rgb   = rgb_reg;
    assign issue.last  = pix_last;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (adv && done)
        begin
            busy_next = 1'b0;
        end
        else if (adv && busy_reg)
        begin
            k_next = k_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_ch.operation;
            byte_reg  <= in_ch.pixel_byte;
            entry_reg <= in_ch.entry_index;
            rgb_reg   <= {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue};
        end
    end

endmodule

// File: design/ppe_pack.sv
// Stage 3: packs palette read data into RGB565-style words; output register.
// Depends on ppe_pkg and ppe_color_if.
module ppe_pack (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ppe_pkg::rd_stage_t          rd,
    input  logic [ppe_pkg::RGB_W-1:0]   rdata,
    output logic                        adv,
    ppe_color_if.source                 out_ch
);

    logic                        valid_reg;
    logic [ppe_pkg::COLOR_W-1:0] color_reg;
    logic                        last_reg;
    logic [ppe_pkg::COLOR_W-1:0] color_next;

    // whole pipe moves when the output register is free or being drained
    assign adv = !valid_reg || out_ch.ready;

    assign color_next = rd.out_of_range ? '0 : ppe_pkg::pack_rgb16(rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= rd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && rd.valid)
        begin
            color_reg <= color_next;
            last_reg  <= rd.last;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.color_word   = color_reg;
    assign out_ch.last_of_byte = last_reg;

endmodule
